// File: rtl/core/restoring_divider_128_macros.svh
// assertion helpers for the divider checker
`ifndef RESTORING_DIVIDER_128_MACROS_SVH
`define RESTORING_DIVIDER_128_MACROS_SVH

// same-cycle implication
`define RDIV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RDIV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/rdiv128_pkg.sv
package rdiv128_pkg;

   localparam int FULL_BITS = 128;
   localparam int HALF_BITS = 64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic take_req;
      logic step;
   } ctrl_type;

endpackage

// File: rtl/core/restoring_divider_128.sv
// after a word is accepted the quotient is formed one quotient bit per cycle, then rsp_valid rises
// zero divisor: the result shows in the cycle after the word is accepted
// only one word is in flight at a time, set by the single shared subtractor
// req_stall stays high from acceptance until the result word has been taken
// reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid
module restoring_divider_128 #(
   parameter int WIDTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rdiv128_pkg::HALF_BITS-1:0] req_dividend_hi,
   input  logic [rdiv128_pkg::HALF_BITS-1:0] req_dividend_lo,
   input  logic [rdiv128_pkg::HALF_BITS-1:0] req_divisor_hi,
   input  logic [rdiv128_pkg::HALF_BITS-1:0] req_divisor_lo,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rdiv128_pkg::HALF_BITS-1:0] rsp_quotient_hi,
   output logic [rdiv128_pkg::HALF_BITS-1:0] rsp_quotient_lo,
   output logic [rdiv128_pkg::HALF_BITS-1:0] rsp_remainder_hi,
   output logic [rdiv128_pkg::HALF_BITS-1:0] rsp_remainder_lo,
   output logic                              rsp_divide_by_zero
);

   localparam int FULL = rdiv128_pkg::FULL_BITS;
   localparam int HALF = rdiv128_pkg::HALF_BITS;
   localparam int CW   = $clog2(WIDTH);

   rdiv128_pkg::state_type state_ff, state_in;
   rdiv128_pkg::ctrl_type  ctrl;

   logic [CW-1:0]    cnt_ff;
   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] den_ff;
   logic             dz_ff;

   logic [FULL-1:0]  dvd_full;
   logic [FULL-1:0]  dsr_full;
   logic [WIDTH-1:0] dvd;
   logic [WIDTH-1:0] dsr;
   logic             dsr_zero;
   logic             last_step;

   logic [WIDTH:0]   trial;
   logic [WIDTH+1:0] diff;
   logic             fits;

   logic [FULL-1:0]  quo_wide;
   logic [FULL-1:0]  rem_wide;

   assign dvd_full  = {req_dividend_hi, req_dividend_lo};
   assign dsr_full  = {req_divisor_hi, req_divisor_lo};
   assign dvd       = dvd_full[WIDTH-1:0];
   assign dsr       = dsr_full[WIDTH-1:0];
   assign dsr_zero  = (dsr == '0);
   assign last_step = (cnt_ff == '0);

   // shared compare and subtract
   assign trial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign fits  = ~diff[WIDTH+1];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rdiv128_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dsr_zero ? rdiv128_pkg::ST_DONE : rdiv128_pkg::ST_BUSY;
            end
         end
         rdiv128_pkg::ST_BUSY: begin
            if (last_step) begin
               state_in = rdiv128_pkg::ST_DONE;
            end
         end
         rdiv128_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = rdiv128_pkg::ST_IDLE;
            end
         end
         default: state_in = rdiv128_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      rsp_valid     = 1'b0;
      ctrl.take_req = 1'b0;
      ctrl.step     = 1'b0;
      unique case (state_ff)
         rdiv128_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            ctrl.take_req = req_valid;
         end
         rdiv128_pkg::ST_BUSY: begin
            ctrl.step = 1'b1;
         end
         rdiv128_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdiv128_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take_req) begin
         cnt_ff <= CW'(WIDTH - 1);
         den_ff <= dsr;
         dz_ff  <= dsr_zero;
         if (dsr_zero) begin
            quo_ff <= '0;
            rem_ff <= dvd;
         end else begin
            quo_ff <= dvd;
            rem_ff <= '0;
         end
      end else if (ctrl.step) begin
         cnt_ff <= cnt_ff - 1'b1;
         quo_ff <= {quo_ff[WIDTH-2:0], fits};
         rem_ff <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      end
   end

   assign quo_wide = FULL'(quo_ff);
   assign rem_wide = FULL'(rem_ff);

   assign rsp_quotient_hi    = quo_wide[FULL-1:HALF];
   assign rsp_quotient_lo    = quo_wide[HALF-1:0];
   assign rsp_remainder_hi   = rem_wide[FULL-1:HALF];
   assign rsp_remainder_lo   = rem_wide[HALF-1:0];
   assign rsp_divide_by_zero = dz_ff;

endmodule

// File: rtl/core/rdiv128_checker.sv
`include "restoring_divider_128_macros.svh"

module rdiv128_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [rdiv128_pkg::HALF_BITS-1:0] req_divisor_hi,
   input logic [rdiv128_pkg::HALF_BITS-1:0] req_divisor_lo,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [rdiv128_pkg::HALF_BITS-1:0] rsp_quotient_hi,
   input logic [rdiv128_pkg::HALF_BITS-1:0] rsp_quotient_lo,
   input logic                              rsp_divide_by_zero
);

   logic req_take;
   logic dsr_zero;

   assign req_take = req_valid && !req_stall;
   assign dsr_zero = (req_divisor_hi == '0) && (req_divisor_lo == '0);

   `RDIV_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")
   `RDIV_ASSERT_NOW(a_busy_with_rsp, clock, reset, rsp_valid, req_stall, "request taken while a result word waits")
   `RDIV_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, req_stall, "request taken back to back")
   `RDIV_ASSERT_NEXT(a_zero_fast, clock, reset, req_take && dsr_zero, rsp_valid && rsp_divide_by_zero, "zero divisor not flagged at once")
   `RDIV_ASSERT_NOW(a_zero_quot, clock, reset, rsp_valid && rsp_divide_by_zero, (rsp_quotient_hi == '0) && (rsp_quotient_lo == '0), "quotient not zero on divide by zero")

endmodule

bind restoring_divider_128 rdiv128_checker u_rdiv128_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_divisor_hi     (req_divisor_hi),
   .req_divisor_lo     (req_divisor_lo),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_quotient_hi    (rsp_quotient_hi),
   .rsp_quotient_lo    (rsp_quotient_lo),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

// File: test/tb_restoring_divider_128.sv
`timescale 1ns / 100ps

module tb_restoring_divider_128;

   localparam int FULL_BITS = rdiv128_pkg::FULL_BITS;
   localparam int HALF_BITS = rdiv128_pkg::HALF_BITS;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = FULL_BITS + 20;
   localparam int unsigned RANDOM_WORDS = 400;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef logic [FULL_BITS-1:0] u128_type;

   typedef struct {
      u128_type dividend;
      u128_type divisor;
      bit       drain_first;
   } div_req_type;

   typedef struct {
      u128_type quotient;
      u128_type remainder;
      logic     divide_by_zero;
   } div_rsp_type;

   localparam u128_type ALL_ONES = {FULL_BITS{1'b1}};
   localparam u128_type TOP_BIT  = u128_type'(1) << (FULL_BITS - 1);

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic [HALF_BITS-1:0] req_dividend_hi = '0;
   logic [HALF_BITS-1:0] req_dividend_lo = '0;
   logic [HALF_BITS-1:0] req_divisor_hi  = '0;
   logic [HALF_BITS-1:0] req_divisor_lo  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic [HALF_BITS-1:0] rsp_quotient_hi;
   logic [HALF_BITS-1:0] rsp_quotient_lo;
   logic [HALF_BITS-1:0] rsp_remainder_hi;
   logic [HALF_BITS-1:0] rsp_remainder_lo;
   logic                 rsp_divide_by_zero;

   div_req_type pending_words[$];
   div_rsp_type results_due[$];
   bit          req_taken   = 1'b0;
   bit          calm        = 1'b0;
   int unsigned req_gap     = 0;
   int unsigned rsp_gap     = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned rsp_count   = 0;

   restoring_divider_128 u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic div_rsp_type divide_128(u128_type dividend, u128_type divisor);
      div_rsp_type r;
      r.divide_by_zero = (divisor == '0);
      if (divisor == '0) begin
         r.quotient  = '0;
         r.remainder = dividend;
      end else begin
         r.quotient  = dividend / divisor;
         r.remainder = dividend % divisor;
      end
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 150);
   endfunction

   // random value whose top set bit is bit len-1, or zero for len 0
   function automatic u128_type rand_bits(int unsigned len);
      u128_type v;
      v = {$urandom, $urandom, $urandom, $urandom};
      if (len == 0) return '0;
      if (len < FULL_BITS) v = v & ((u128_type'(1) << len) - u128_type'(1));
      v[len-1] = 1'b1;
      return v;
   endfunction

   task automatic add_word(u128_type dividend, u128_type divisor, bit drain_first);
      div_req_type w;
      w.dividend    = dividend;
      w.divisor     = divisor;
      w.drain_first = drain_first;
      pending_words.push_back(w);
   endtask

   task automatic add_random_words(int unsigned n);
      u128_type    a;
      u128_type    b;
      int unsigned roll;
      for (int unsigned i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         a    = rand_bits($urandom_range(0, FULL_BITS));
         b    = rand_bits($urandom_range(1, FULL_BITS));
         if (roll < 6) begin
            b = '0;
         end else if (roll < 14) begin
            a = {$urandom, $urandom, $urandom, $urandom};
            b = {$urandom, $urandom, $urandom, $urandom};
         end else if (roll < 20) begin
            b = a + u128_type'($urandom_range(0, 2)) - u128_type'(1);
         end else if (roll < 30) begin
            a = rand_bits($urandom_range(100, FULL_BITS));
            b = rand_bits($urandom_range(1, 8));
         end else if (roll < 34) begin
            a = ALL_ONES;
         end
         add_word(a, b, (i % 97) == 50);
      end
   endtask

   // sender
   always @(negedge clock) begin
      div_req_type w;
      logic        next_valid;
      next_valid = req_valid;
      if (!reset && (!req_valid || req_taken)) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_words.size() > 0 &&
                      (!pending_words[0].drain_first ||
                       (results_due.size() == 0 && !req_valid))) begin
            w = pending_words.pop_front();
            req_dividend_hi <= w.dividend[FULL_BITS-1:HALF_BITS];
            req_dividend_lo <= w.dividend[HALF_BITS-1:0];
            req_divisor_hi  <= w.divisor[FULL_BITS-1:HALF_BITS];
            req_divisor_lo  <= w.divisor[HALF_BITS-1:0];
            next_valid = 1'b1;
            req_gap    = pick_gap();
            if ($urandom_range(0, 39) == 0) calm = !calm;
         end
      end
      req_valid <= next_valid;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_stall <= 1'b1;
         rsp_gap--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) rsp_gap = pick_gap();
      end
   end

   always @(posedge clock) begin
      div_rsp_type want;
      u128_type    got_q;
      u128_type    got_r;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("restoring_divider_128: mismatch");
         $finish;
      end else begin
         req_taken <= !reset && req_valid && !req_stall;
         if (!reset) begin
            if (req_valid && !req_stall) begin
               results_due.push_back(divide_128({req_dividend_hi, req_dividend_lo},
                                                {req_divisor_hi, req_divisor_lo}));
            end
            if (rsp_valid && !rsp_stall) begin
               got_q = {rsp_quotient_hi, rsp_quotient_lo};
               got_r = {rsp_remainder_hi, rsp_remainder_lo};
               if (results_due.size() == 0) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("result word %0d arrived with none outstanding", rsp_count);
               end else begin
                  want = results_due.pop_front();
                  if (got_q !== want.quotient || got_r !== want.remainder ||
                      rsp_divide_by_zero !== want.divide_by_zero) begin
                     error_count++;
                     if (error_count <= REPORT_LIMIT) begin
                        $display("result word %0d: got q=%h r=%h dz=%b", rsp_count,
                                 got_q, got_r, rsp_divide_by_zero);
                        $display("   expected q=%h r=%h dz=%b",
                                 want.quotient, want.remainder, want.divide_by_zero);
                     end
                  end
               end
               rsp_count++;
            end
         end
      end
   end

   initial begin
      add_word('0, '0, 1'b0);
      add_word(ALL_ONES, '0, 1'b0);
      add_word('0, u128_type'(1), 1'b0);
      add_word(ALL_ONES, u128_type'(1), 1'b0);
      add_word(ALL_ONES, ALL_ONES, 1'b0);
      add_word(u128_type'(1), ALL_ONES, 1'b0);
      add_word(ALL_ONES, TOP_BIT, 1'b0);
      add_word(TOP_BIT, u128_type'(3), 1'b0);
      add_word(128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
               128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210, 1'b0);
      add_word(128'h0123_4567_89ab_cdef_fedc_ba98_7654_320f,
               128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210, 1'b0);
      add_word(ALL_ONES, {{HALF_BITS{1'b0}}, {HALF_BITS{1'b1}}}, 1'b0);
      add_word({{HALF_BITS{1'b1}}, {HALF_BITS{1'b0}}}, u128_type'(1) << HALF_BITS, 1'b0);
      add_word(u128_type'(1) << HALF_BITS, {{HALF_BITS{1'b0}}, {HALF_BITS{1'b1}}}, 1'b0);
      add_word(u128_type'(7), u128_type'(3), 1'b0);
      add_word(u128_type'(100), u128_type'(7), 1'b1);
      add_word(ALL_ONES, {(FULL_BITS/2){2'b01}}, 1'b0);
      add_word({(FULL_BITS/2){2'b10}}, u128_type'(3), 1'b0);
      add_word(u128_type'(1), u128_type'(1), 1'b0);
      add_word(ALL_ONES, ALL_ONES - u128_type'(1), 1'b0);
      add_word(ALL_ONES - u128_type'(1), ALL_ONES, 1'b0);
      add_random_words(RANDOM_WORDS);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += results_due.size();

      if (error_count == 0) begin
         $display("restoring_divider_128: match");
      end else begin
         $display("restoring_divider_128: mismatch");
      end
      $finish;
   end

endmodule
